[sv/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared constants and types for the stream group reverse block.
// ----------------------------------------------------------------------------
package sgr_pkg;

   // data word and register widths
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 5;
   localparam int MAX_GROUP = 16;

   // group size after reset
   localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd1;

   // control from the sequencer to the datapath
   typedef struct packed {
      logic in_ready;   // sequencer can take an input word
      logic rd_en;      // buffer read issued this cycle
      logic rd_last;    // issued read is the last word of the sequence
   } sgr_ctrl_type;

endpackage

[sv/sgr_if.sv]
// ----------------------------------------------------------------------------
// sgr_if
// Valid/ready channels for the request and response streams.
// ----------------------------------------------------------------------------
interface sgr_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [sgr_pkg::DATA_W-1:0]  item_value;
   logic                               end_of_list;

   modport source (output valid, output item_value, output end_of_list, input ready);
   modport sink   (input valid, input item_value, input end_of_list, output ready);
endinterface

interface sgr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sgr_pkg::DATA_W-1:0]  out_value;
   logic                               out_last;

   modport source (output valid, output out_value, output out_last, input ready);
   modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

[sv/sgr_ctrl.sv]
// ----------------------------------------------------------------------------
// sgr_ctrl
// Fill counter and drain sequencer: picks buffer write and read addresses.
// ----------------------------------------------------------------------------
module sgr_ctrl #(
   parameter int MAX_GROUP = sgr_pkg::MAX_GROUP,
   parameter int AW        = $clog2(MAX_GROUP),
   parameter int CNT_W     = $clog2(MAX_GROUP + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CNT_W-1:0]       k_eff,
   input  logic                   acc,
   input  logic                   acc_last,
   input  logic                   rd_free,
   output logic [AW-1:0]          wr_addr,
   output logic [AW-1:0]          rd_addr,
   output sgr_pkg::sgr_ctrl_type  ctl
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic             rev_ff, rev_in;
   logic             last_ff, last_in;

   logic [AW-1:0]    wr_idx;
   logic [CNT_W-1:0] n_cnt;
   logic             full_grp;
   logic             flush;
   logic             issue;

   // write slot, clamped to the top entry
   assign wr_idx   = (fill_ff >= CNT_W'(MAX_GROUP)) ? AW'(MAX_GROUP - 1) : fill_ff[AW-1:0];
   assign n_cnt    = CNT_W'(wr_idx) + CNT_W'(1);
   assign full_grp = (n_cnt >= k_eff);
   assign flush    = full_grp || acc_last;
   assign issue    = (state_ff == ST_DRAIN) && rd_free;

   assign wr_addr     = wr_idx;
   assign rd_addr     = addr_ff;
   assign ctl.in_ready = (state_ff == ST_IDLE);
   assign ctl.rd_en    = issue;
   assign ctl.rd_last  = last_ff && (rem_ff == CNT_W'(1));

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      rem_in   = rem_ff;
      addr_in  = addr_ff;
      rev_in   = rev_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (flush) begin
                  // full group drains newest first, a short tail oldest first
                  state_in = ST_DRAIN;
                  fill_in  = '0;
                  rem_in   = n_cnt;
                  rev_in   = full_grp;
                  addr_in  = full_grp ? wr_idx : '0;
                  last_in  = acc_last;
               end else begin
                  fill_in = n_cnt;
               end
            end
         end
         ST_DRAIN: begin
            if (issue) begin
               rem_in  = rem_ff - CNT_W'(1);
               addr_in = rev_ff ? (addr_ff - AW'(1)) : (addr_ff + AW'(1));
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rem_ff   <= rem_in;
      end
   end

   // drain bookkeeping, no reset needed
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rev_ff  <= rev_in;
      last_ff <= last_in;
   end

`ifndef SYNTHESIS
   // a partial group never fills the whole buffer
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CNT_W'(MAX_GROUP))
      else $error("fill count reached buffer depth");

   // a drain always has words left to read
   a_drain_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rem_ff != '0))
      else $error("drain with nothing left");

   // a word that does not close a group is counted
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (acc && !flush) |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("fill count did not advance");

   // a closing word starts a drain with an empty fill count
   a_flush_drain: assert property (@(posedge clock) disable iff (reset)
      (acc && flush) |=> (state_ff == ST_DRAIN) && (fill_ff == '0))
      else $error("closing word did not start drain");
`endif

endmodule

[sv/stream_group_reverse_top.sv]
// Path: a group's closing word starts the drain; reads pass the read stage register,
// then the output register. Throughput: one input word per cycle as a group fills;
// drain is one word per cycle (read port bound) unless rsp stalls; input held off.
// Reset: group size returns to 1 and the fill count to 0; buffer contents are kept.
// ----------------------------------------------------------------------------
// stream_group_reverse_top
// Reverses a word stream in groups of k through a buffer memory; a short
// tail at end of sequence leaves in arrival order.
// ----------------------------------------------------------------------------
module stream_group_reverse_top #(
   parameter int MAX_GROUP = sgr_pkg::MAX_GROUP
) (
   input  logic                      clock,
   input  logic                      reset,
   sgr_req_if.sink                   req,
   sgr_rsp_if.source                 rsp,
   input  logic                      csr_wr_en,
   input  logic [sgr_pkg::CFG_W-1:0] csr_wr_data
);

   localparam int AW    = $clog2(MAX_GROUP);
   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int KW    = (CNT_W > sgr_pkg::CFG_W) ? CNT_W : sgr_pkg::CFG_W;

   logic [sgr_pkg::CFG_W-1:0]  group_size_ff;
   logic [KW-1:0]              gs_ext;
   logic [CNT_W-1:0]           k_eff;

   sgr_pkg::sgr_ctrl_type      ctl;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr;
   logic                       acc;
   logic                       move;
   logic                       rd_free;

   logic [sgr_pkg::DATA_W-1:0] grp_mem [MAX_GROUP];
   logic [sgr_pkg::DATA_W-1:0] rd_data_ff;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rd_last_ff;
   logic [sgr_pkg::DATA_W-1:0] out_value_ff;
   logic                       out_last_ff;
   logic                       out_vld_ff, out_vld_in;

   // group size register
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= sgr_pkg::GROUP_SIZE_RESET;
      end else if (csr_wr_en) begin
         group_size_ff <= csr_wr_data;
      end
   end

   // zero acts as one, oversize acts as buffer depth
   assign gs_ext = KW'(group_size_ff);
   always_comb begin
      priority if (gs_ext == '0) begin
         k_eff = CNT_W'(1);
      end else if (gs_ext > KW'(MAX_GROUP)) begin
         k_eff = CNT_W'(MAX_GROUP);
      end else begin
         k_eff = CNT_W'(gs_ext);
      end
   end

   assign req.ready = ctl.in_ready;
   assign acc       = req.valid && ctl.in_ready;

   sgr_ctrl #(
      .MAX_GROUP (MAX_GROUP),
      .AW        (AW),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .k_eff    (k_eff),
      .acc      (acc),
      .acc_last (req.end_of_list),
      .rd_free  (rd_free),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .ctl      (ctl)
   );

   // group buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (acc) begin
         grp_mem[wr_addr] <= req.item_value;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= grp_mem[rd_addr];
         rd_last_ff <= ctl.rd_last;
      end
   end

   // read stage hands to output register when it is free or being taken
   assign move    = rd_vld_ff && (!out_vld_ff || rsp.ready);
   assign rd_free = !rd_vld_ff || move;

   always_comb begin
      rd_vld_in = rd_vld_ff;
      if (ctl.rd_en) begin
         rd_vld_in = 1'b1;
      end else if (move) begin
         rd_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (move) begin
         out_value_ff <= rd_data_ff;
         out_last_ff  <= rd_last_ff;
      end
   end

   assign rsp.valid     = out_vld_ff;
   assign rsp.out_value = out_value_ff;
   assign rsp.out_last  = out_last_ff;

`ifndef SYNTHESIS
   // effective group size always within the buffer
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (k_eff != '0) && (k_eff <= CNT_W'(MAX_GROUP)))
      else $error("group size out of range");

   // a read is never issued into an occupied, stalled read stage
   a_rd_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> rd_free)
      else $error("read would overwrite pending word");

   // input is held off while words are read out
   a_no_acc_drain: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> !acc)
      else $error("input taken during drain");
`endif

endmodule

[tb/stream_group_reverse_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_group_reverse_top_test
// Self-checking bench for the group reverse block. A driver and a monitor run
// as clocked always blocks. The monitor predicts each group's output order
// when a word is taken, and checks every response word against the oldest
// prediction. Group size is changed only while the block is idle.
// ----------------------------------------------------------------------------
module stream_group_reverse_top_test;

   typedef struct {
      logic [sgr_pkg::DATA_W-1:0] value;
      logic                       eol;
   } list_word_type;

   typedef struct {
      logic [sgr_pkg::DATA_W-1:0] value;
      logic                       last;
   } out_word_type;

   typedef enum logic [1:0] {READY_ALWAYS, READY_PATTERN, READY_RANDOM} stall_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [sgr_pkg::CFG_W-1:0] csr_wr_data;

   sgr_req_if req_if ();
   sgr_rsp_if rsp_if ();

   stream_group_reverse_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // stimulus and prediction state
   list_word_type              pending_words[$];
   out_word_type               expected_words[$];
   logic [sgr_pkg::DATA_W-1:0] held_words[sgr_pkg::MAX_GROUP];
   int                         words_held;
   logic [sgr_pkg::CFG_W-1:0]  group_size_cfg;
   int                         error_count;

   // driver handshake bookkeeping
   bit req_busy;
   bit req_taken;
   int burst_left;
   int gap_left;

   // receiver stall state
   stall_mode_type ready_mode;
   int             ready_mode_left;
   logic [15:0]    ready_pattern;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // mirror of the block: buffer the word, emit a full group reversed or a
   // short tail in arrival order at end of sequence
   function automatic void predict_reorder(input logic [sgr_pkg::DATA_W-1:0] value,
                                           input logic eol);
      int           k;
      int           n;
      out_word_type w;
      k = group_size_cfg;
      if (k < 1) k = 1;
      if (k > sgr_pkg::MAX_GROUP) k = sgr_pkg::MAX_GROUP;
      if (words_held >= sgr_pkg::MAX_GROUP) words_held = sgr_pkg::MAX_GROUP - 1;
      held_words[words_held] = value;
      words_held++;
      n = words_held;
      if (n >= k) begin
         for (int i = 0; i < n; i++) begin
            w.value = held_words[n-1-i];
            w.last  = eol && (i == n - 1);
            expected_words.push_back(w);
         end
         words_held = 0;
      end else if (eol) begin
         for (int i = 0; i < n; i++) begin
            w.value = held_words[i];
            w.last  = (i == n - 1);
            expected_words.push_back(w);
         end
         words_held = 0;
      end
   endfunction

   // extremes show up often, the rest is uniform
   function automatic logic [sgr_pkg::DATA_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // extremes and out-of-range codes are favored
   function automatic logic [sgr_pkg::CFG_W-1:0] pick_group_size();
      case ($urandom_range(0, 9))
         0:       return 5'd1;
         1:       return 5'd16;
         2:       return 5'd0;
         3:       return 5'($urandom_range(17, 31));
         default: return 5'($urandom_range(2, 15));
      endcase
   endfunction

   task automatic push_word(input logic [sgr_pkg::DATA_W-1:0] value, input logic eol);
      list_word_type w;
      w.value = value;
      w.eol   = eol;
      pending_words.push_back(w);
   endtask

   // wait until every word is sent and every response is back, then let the
   // pipeline settle
   task automatic wait_idle();
      int cycles;
      cycles = 0;
      while ((pending_words.size() != 0 || req_busy || expected_words.size() != 0)
             && cycles < 20000) begin
         @(posedge clock);
         cycles++;
      end
      if (expected_words.size() != 0 || pending_words.size() != 0 || req_busy) begin
         $error("stream stuck: %0d words unsent, %0d responses missing",
                pending_words.size(), expected_words.size());
         error_count++;
      end
      repeat (24) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [sgr_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= value;
      group_size_cfg  = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver: bursts of words with random gaps
   always @(negedge clock) begin : req_driver
      list_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy  = 1'b0;
         end
         if (!req_busy) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               w = pending_words.pop_front();
               req_if.valid       <= 1'b1;
               req_if.item_value  <= w.value;
               req_if.end_of_list <= w.eol;
               req_busy = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  if ($urandom_range(0, 3) == 0) begin
                     burst_left = 40;
                     gap_left   = 0;
                  end else begin
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(0, 6);
                  end
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response ready: always on, a rotating mask, or random
   always @(negedge clock) begin : rsp_stall
      if (ready_mode_left <= 0) begin
         ready_mode      = stall_mode_type'($urandom_range(0, 2));
         ready_mode_left = $urandom_range(20, 80);
         ready_pattern   = 16'($urandom) | 16'h0001;
      end
      ready_mode_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_if.ready <= 1'b1;
         READY_PATTERN: begin
            rsp_if.ready  <= ready_pattern[0];
            ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
         end
         default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // monitor: check responses, then predict from the word taken this edge
   always @(posedge clock) begin : monitor
      out_word_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected response word: out_value %h out_last %b",
                      rsp_if.out_value, rsp_if.out_last);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_if.out_value !== want.value) begin
                  $error("out_value: expected %h, actual %h", want.value, rsp_if.out_value);
                  error_count++;
               end
               if (rsp_if.out_last !== want.last) begin
                  $error("out_last: expected %b, actual %b", want.last, rsp_if.out_last);
                  error_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_reorder(req_if.item_value, req_if.end_of_list);
            req_taken = 1'b1;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int                        random_items;
      int                        k;
      int                        len;
      bit                        broken;
      logic [sgr_pkg::CFG_W-1:0] cfg;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.item_value  = '0;
      req_if.end_of_list = 1'b0;
      rsp_if.ready       = 1'b0;
      group_size_cfg     = sgr_pkg::GROUP_SIZE_RESET;
      words_held         = 0;
      error_count        = 0;
      req_busy           = 1'b0;
      req_taken          = 1'b0;
      burst_left         = 1;
      gap_left           = 0;
      ready_mode_left    = 0;
      random_items       = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset group size: straight pass-through, end flag both ways
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'h8000_0000, 1'b1);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h0000_0000, 1'b1);
      wait_idle();

      // sequence ends on a full group, then a short tail
      write_group_size(5'd4);
      push_word(32'h0000_0001, 1'b0);
      push_word(32'hAAAA_AAAA, 1'b0);
      push_word(32'h5555_5555, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b1);
      push_word(32'h1234_5678, 1'b0);
      push_word(32'h8765_4321, 1'b1);
      wait_idle();

      // group size zero behaves as one
      write_group_size(5'd0);
      push_word(32'hDEAD_BEEF, 1'b0);
      push_word(32'h0BAD_F00D, 1'b1);
      wait_idle();

      // oversize code clamps to the buffer depth
      write_group_size(5'd31);
      push_word(32'h0000_0011, 1'b0);
      push_word(32'h0000_0022, 1'b0);
      push_word(32'h0000_0033, 1'b1);
      wait_idle();

      // shrink the group with words already held: all of them leave reversed
      write_group_size(5'd5);
      push_word(32'hC000_0001, 1'b0);
      push_word(32'hC000_0002, 1'b0);
      push_word(32'hC000_0003, 1'b0);
      wait_idle();
      write_group_size(5'd2);
      push_word(32'hC000_0004, 1'b0);
      wait_idle();

      // random phases: mostly whole sequences, some left open across a resize
      while (random_items < 170) begin
         cfg = pick_group_size();
         write_group_size(cfg);
         k = (cfg == 0) ? 1 : (cfg > sgr_pkg::MAX_GROUP) ? sgr_pkg::MAX_GROUP : int'(cfg);
         repeat ($urandom_range(1, 3)) begin
            len = $urandom_range(0, 3) * k + $urandom_range(0, k - 1);
            if (len == 0) len = k;
            if (len > 48) len = 48;
            broken = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < len; i++)
               push_word(rand_word(), (i == len - 1) && !broken);
            random_items += len;
         end
         wait_idle();
      end

      // flush anything still held so the last group comes out
      push_word(rand_word(), 1'b1);
      wait_idle();

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
sv/sgr_pkg.sv
sv/sgr_if.sv
sv/sgr_ctrl.sv
sv/stream_group_reverse_top.sv
tb/stream_group_reverse_top_test.sv
